// ===== hw/rtl/ps2mct_pkg.sv =====
package ps2mct_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } phase_e;

  localparam int unsigned HdrLeft  = 0;
  localparam int unsigned HdrOne   = 3;
  localparam int unsigned HdrXSign = 4;
  localparam int unsigned HdrYSign = 5;
  localparam int unsigned HdrXOvf  = 6;
  localparam int unsigned HdrYOvf  = 7;

  localparam logic [1:0] RegClampWidth   = 2'd0;
  localparam logic [1:0] RegClampHeight  = 2'd1;
  localparam logic [1:0] RegIconSize     = 2'd2;
  localparam logic [1:0] RegDisplayWidth = 2'd3;

  localparam logic [11:0] ClampWidthRst   = 12'd720;
  localparam logic [11:0] ClampHeightRst  = 12'd400;
  localparam logic [9:0]  IconSizeRst     = 10'd40;
  localparam logic [11:0] DisplayWidthRst = 12'd720;

  localparam logic [2:0] ClickNone  = 3'd0;
  localparam logic [2:0] ClickIcon0 = 3'd1;
  localparam logic [2:0] ClickIcon1 = 3'd2;
  localparam logic [2:0] ClickIcon2 = 3'd3;
  localparam logic [2:0] ClickMin   = 3'd4;

  typedef struct packed {
    logic [11:0] clamp_width;
    logic [11:0] clamp_height;
    logic [9:0]  icon_size;
    logic [11:0] display_width;
  } cfg_t;

  typedef struct packed {
    logic       left;
    logic       x_sign;
    logic       y_sign;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

endpackage

// ===== hw/rtl/ps2mct_update.sv =====
module ps2mct_update #(
  parameter int unsigned POS_BITS = 12
) (
  input  logic [POS_BITS-1:0] cur_x_i,
  input  logic [POS_BITS-1:0] cur_y_i,
  input  ps2mct_pkg::pkt_t    pkt_i,
  input  ps2mct_pkg::cfg_t    cfg_i,
  output logic [POS_BITS-1:0] new_x_o,
  output logic [POS_BITS-1:0] new_y_o,
  output logic [2:0]          click_o
);
  import ps2mct_pkg::*;

  localparam int unsigned BW = (POS_BITS > 12) ? POS_BITS : 12;
  localparam int unsigned VW = BW + 2;
  localparam logic [BW-1:0] PosMax = BW'((33'd1 << POS_BITS) - 33'd1);

  function automatic logic [POS_BITS-1:0] clamp_pos(logic signed [VW-1:0] v,
                                                    logic [11:0] size);
    logic [BW-1:0] hi;
    logic [BW-1:0] res;
    hi = (size == 12'd0) ? '0 : BW'(size - 12'd1);
    if (hi > PosMax) begin
      hi = PosMax;
    end
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({2'b00, hi})) begin
      res = hi;
    end else begin
      res = v[BW-1:0];
    end
    return res[POS_BITS-1:0];
  endfunction

  logic signed [VW-1:0] dx_ext, dy_ext, sum_x, sum_y;
  logic signed [VW-1:0] x_e, y_e, s1, s2, s3, dw_e, min_lo;

  assign dx_ext = VW'($signed({pkt_i.x_sign, pkt_i.dx}));
  assign dy_ext = VW'($signed({pkt_i.y_sign, pkt_i.dy}));
  assign sum_x  = $signed(VW'(cur_x_i)) + dx_ext;
  assign sum_y  = $signed(VW'(cur_y_i)) - dy_ext;
  assign new_x_o = clamp_pos(sum_x, cfg_i.clamp_width);
  assign new_y_o = clamp_pos(sum_y, cfg_i.clamp_height);

  assign x_e    = $signed(VW'(new_x_o));
  assign y_e    = $signed(VW'(new_y_o));
  assign s1     = $signed(VW'(cfg_i.icon_size));
  assign s2     = s1 <<< 1;
  assign s3     = s2 + s1;
  assign dw_e   = $signed(VW'(cfg_i.display_width));
  assign min_lo = dw_e - s1;

  always_comb begin
    click_o = ClickNone;
    if (pkt_i.left && (y_e < s1)) begin
      if (x_e < s1) begin
        click_o = ClickIcon0;
      end
      if ((x_e >= s1) && (x_e < s2)) begin
        click_o = ClickIcon1;
      end
      if ((x_e >= s2) && (x_e < s3)) begin
        click_o = ClickIcon2;
      end
      if ((x_e >= min_lo) && (x_e < dw_e)) begin
        click_o = ClickMin;
      end
    end
  end

endmodule

// ===== hw/rtl/ps2_mouse_cursor_tracker.sv =====
// Channel | Direction | Handshake                 | Payload
// cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// in      | in        | in_valid_i / in_stall_o   | data_byte_i
// out     | out       | out_valid_o / out_stall_i | pos_x_o, pos_y_o, prev_x_o, prev_y_o,
//         |           |                           | left_button_o, click_action_o
//
// One byte is taken every cycle while in_stall_o is low; a valid third byte enters the packet
// register, and its result is registered in the output register once the output is not stalled.
// The packet register and the output register together hold two packets, so input
// stalls only when both are full and the output is stalled.
// Reset clears the byte phase, holds, cursor and valid flags and sets the configuration registers to their defaults.
// Configuration writes are always ready and take effect at once.
module ps2_mouse_cursor_tracker #(
  parameter int unsigned POS_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [POS_BITS-1:0] pos_x_o,
  output logic [POS_BITS-1:0] pos_y_o,
  output logic [POS_BITS-1:0] prev_x_o,
  output logic [POS_BITS-1:0] prev_y_o,
  output logic                left_button_o,
  output logic [2:0]          click_action_o
);
  import ps2mct_pkg::*;

  cfg_t   cfg_q, cfg_d;
  phase_e phase_q, phase_d;
  logic [7:0] header_q, header_d, dx_q, dx_d;
  logic [POS_BITS-1:0] cur_x_q, cur_y_q;
  logic pkt_valid_q, pkt_valid_d;
  pkt_t pkt_q;
  logic out_valid_q, out_valid_d;
  logic [POS_BITS-1:0] new_x, new_y;
  logic [2:0] click;
  logic [POS_BITS-1:0] pos_x_q, pos_y_q, prev_x_q, prev_y_q;
  logic left_q;
  logic [2:0] click_q;
  logic in_acc, pkt_go, pkt_load, hdr_ok;

  assign cfg_ready_o = 1'b1;
  assign pkt_go      = pkt_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = pkt_valid_q && !pkt_go;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign hdr_ok      = !header_q[HdrXOvf] && !header_q[HdrYOvf] && header_q[HdrOne];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegClampWidth:   cfg_d.clamp_width   = cfg_data_i;
        RegClampHeight:  cfg_d.clamp_height  = cfg_data_i;
        RegIconSize:     cfg_d.icon_size     = cfg_data_i[9:0];
        RegDisplayWidth: cfg_d.display_width = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    dx_d     = dx_q;
    pkt_load = 1'b0;
    if (in_acc) begin
      case (phase_q)
        PH_DX: begin
          dx_d    = data_byte_i;
          phase_d = PH_DY;
        end
        PH_DY: begin
          phase_d  = PH_HEADER;
          pkt_load = hdr_ok;
        end
        default: begin
          header_d = data_byte_i;
          phase_d  = PH_DX;
        end
      endcase
    end
    pkt_valid_d = pkt_load || (pkt_valid_q && !pkt_go);
    out_valid_d = pkt_go || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{clamp_width: ClampWidthRst, clamp_height: ClampHeightRst,
                       icon_size: IconSizeRst, display_width: DisplayWidthRst};
      phase_q     <= PH_HEADER;
      header_q    <= '0;
      dx_q        <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      pkt_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      phase_q     <= phase_d;
      header_q    <= header_d;
      dx_q        <= dx_d;
      pkt_valid_q <= pkt_valid_d;
      out_valid_q <= out_valid_d;
      if (pkt_go) begin
        cur_x_q <= new_x;
        cur_y_q <= new_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_load) begin
      pkt_q <= '{left: header_q[HdrLeft], x_sign: header_q[HdrXSign],
                 y_sign: header_q[HdrYSign], dx: dx_q, dy: data_byte_i};
    end
    if (pkt_go) begin
      pos_x_q  <= new_x;
      pos_y_q  <= new_y;
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
      left_q   <= pkt_q.left;
      click_q  <= click;
    end
  end

  ps2mct_update #(
    .POS_BITS(POS_BITS)
  ) u_update (
    .cur_x_i(cur_x_q),
    .cur_y_i(cur_y_q),
    .pkt_i  (pkt_q),
    .cfg_i  (cfg_q),
    .new_x_o(new_x),
    .new_y_o(new_y),
    .click_o(click)
  );

  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign prev_x_o       = prev_x_q;
  assign prev_y_o       = prev_y_q;
  assign left_button_o  = left_q;
  assign click_action_o = click_q;

  a_stall_needs_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (pkt_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked packet");

  a_go_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_go |=> out_valid_q)
    else $error("packet advanced without producing a result");

  a_cursor_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pkt_go |=> ($stable(cur_x_q) && $stable(cur_y_q)))
    else $error("cursor changed without a packet");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !pkt_go) |=> !out_valid_q)
    else $error("result delivered twice");

endmodule

// ===== bench/ps2_mouse_cursor_tracker_test.sv =====
module ps2_mouse_cursor_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2mct_pkg::*;

  localparam int PosBits = 12;
  localparam int PosMax = (1 << PosBits) - 1;
  localparam int CycleLimit = 500000;
  localparam int NumSetups = 7;
  localparam int PacketsPerSetup = 100;
  localparam int NumRows = 10;

  typedef struct packed {
    logic [PosBits-1:0] x;
    logic [PosBits-1:0] y;
    logic [PosBits-1:0] px;
    logic [PosBits-1:0] py;
    logic               left;
    logic [2:0]         click;
  } cursor_rpt_t;

  typedef struct packed {
    logic [7:0]  hdr;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic        pinned;
    cursor_rpt_t rpt;
  } packet_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = RegClampWidth;
  logic [11:0]        cfg_data_i = 12'd0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         data_byte_i = 8'd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [PosBits-1:0] pos_x_o;
  logic [PosBits-1:0] pos_y_o;
  logic [PosBits-1:0] prev_x_o;
  logic [PosBits-1:0] prev_y_o;
  logic               left_button_o;
  logic [2:0]         click_action_o;

  ps2_mouse_cursor_tracker #(
    .POS_BITS(PosBits)
  ) uut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .out_valid_o,
    .out_stall_i,
    .pos_x_o,
    .pos_y_o,
    .prev_x_o,
    .prev_y_o,
    .left_button_o,
    .click_action_o
  );

  cfg_t track_cfg = '{ClampWidthRst, ClampHeightRst, IconSizeRst, DisplayWidthRst};
  phase_e rx_phase = PH_HEADER;
  logic [7:0] hdr_q = 8'd0;
  logic [7:0] dx_q = 8'd0;
  logic [PosBits-1:0] cur_x = '0;
  logic [PosBits-1:0] cur_y = '0;

  cursor_rpt_t pending_rpts[$];
  cursor_rpt_t pinned_rpt;
  bit pin_valid = 1'b0;

  int err_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  int ModeSend[4] = '{0, 51, 0, 18};
  int ModeStall[4] = '{0, 0, 51, 18};

  cfg_t Setups[NumSetups] = '{
    '{12'd720, 12'd400, 10'd40, 12'd720},
    '{12'd4095, 12'd4095, 10'd1023, 12'd4095},
    '{12'd1, 12'd1, 10'd1, 12'd1},
    '{12'd200, 12'd100, 10'd60, 12'd150},
    '{12'd0, 12'd0, 10'd0, 12'd0},
    '{12'd300, 12'd120, 10'd1023, 12'd100},
    '{12'd64, 12'd64, 10'd21, 12'd4000}
  };

  packet_row_t DirRows[NumRows] = '{
    '{8'h08, 8'h00, 8'h00, 1'b1, '{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, ClickNone}},
    '{8'h09, 8'h10, 8'h00, 1'b1, '{12'd16, 12'd0, 12'd0, 12'd0, 1'b1, ClickIcon0}},
    '{8'h48, 8'h7F, 8'h7F, 1'b0, '0},
    '{8'h88, 8'h01, 8'h01, 1'b0, '0},
    '{8'h01, 8'h22, 8'h33, 1'b0, '0},
    '{8'h19, 8'h00, 8'h00, 1'b1, '{12'd0, 12'd0, 12'd16, 12'd0, 1'b1, ClickIcon0}},
    '{8'h28, 8'h00, 8'h00, 1'b1, '{12'd0, 12'd256, 12'd0, 12'd0, 1'b0, ClickNone}},
    '{8'h28, 8'h00, 8'h00, 1'b1, '{12'd0, 12'd399, 12'd0, 12'd256, 1'b0, ClickNone}},
    '{8'h09, 8'hFF, 8'h7F, 1'b0, '0},
    '{8'h0B, 8'hFF, 8'hFF, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [PosBits-1:0] clamp_coord(int v, logic [11:0] size);
    int hi;
    hi = (size == 0) ? 0 : int'(size) - 1;
    if (hi > PosMax) hi = PosMax;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v[PosBits-1:0];
  endfunction

  function automatic logic [2:0] hot_region(logic [PosBits-1:0] x, logic [PosBits-1:0] y,
                                            cfg_t c);
    int s;
    int dw;
    int xs;
    logic [2:0] act;
    s = int'(c.icon_size);
    dw = int'(c.display_width);
    xs = int'(x);
    act = ClickNone;
    if (int'(y) >= s) return ClickNone;
    if (xs >= 0 && xs < s) act = ClickIcon0;
    if (xs >= s && xs < 2 * s) act = ClickIcon1;
    if (xs >= 2 * s && xs < 3 * s) act = ClickIcon2;
    if (xs >= dw - s && xs < dw) act = ClickMin;
    return act;
  endfunction

  task automatic track_byte(input logic [7:0] b);
    cursor_rpt_t r;
    int dx;
    int dy;
    case (rx_phase)
      PH_DX: begin
        dx_q = b;
        rx_phase = PH_DY;
      end
      PH_DY: begin
        rx_phase = PH_HEADER;
        if (!hdr_q[HdrXOvf] && !hdr_q[HdrYOvf] && hdr_q[HdrOne]) begin
          dx = int'(dx_q) - (hdr_q[HdrXSign] ? 256 : 0);
          dy = int'(b) - (hdr_q[HdrYSign] ? 256 : 0);
          r.px = cur_x;
          r.py = cur_y;
          cur_x = clamp_coord(int'(cur_x) + dx, track_cfg.clamp_width);
          cur_y = clamp_coord(int'(cur_y) - dy, track_cfg.clamp_height);
          r.x = cur_x;
          r.y = cur_y;
          r.left = hdr_q[HdrLeft];
          r.click = r.left ? hot_region(cur_x, cur_y, track_cfg) : ClickNone;
          if (pin_valid) r = pinned_rpt;
          pending_rpts.push_back(r);
        end
        pin_valid = 1'b0;
      end
      default: begin
        hdr_q = b;
        rx_phase = PH_DX;
      end
    endcase
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    cursor_rpt_t got;
    cursor_rpt_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{pos_x_o, pos_y_o, prev_x_o, prev_y_o, left_button_o, click_action_o};
        if (pending_rpts.size() == 0) begin
          note_error($sformatf({"unexpected transaction: x=%0d y=%0d px=%0d py=%0d ",
                                "left=%0b click=%0d"},
                               got.x, got.y, got.px, got.py, got.left, got.click));
        end else begin
          want = pending_rpts.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.px !== want.px ||
              got.py !== want.py || got.left !== want.left || got.click !== want.click) begin
            note_error($sformatf({"mismatch: expected x=%0d y=%0d px=%0d py=%0d left=%0b ",
                                  "click=%0d, got x=%0d y=%0d px=%0d py=%0d left=%0b click=%0d"},
                                 want.x, want.y, want.px, want.py, want.left, want.click,
                                 got.x, got.y, got.px, got.py, got.left, got.click));
          end
        end
      end
      if (in_valid_i && !in_stall_o) track_byte(data_byte_i);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rpts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegClampWidth:   track_cfg.clamp_width = val;
      RegClampHeight:  track_cfg.clamp_height = val;
      RegIconSize:     track_cfg.icon_size = val[9:0];
      RegDisplayWidth: track_cfg.display_width = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_delta(logic sign);
    int k;
    if ($urandom_range(1) == 0) return 8'($urandom_range(255));
    k = $urandom_range(12, 1);
    return sign ? 8'(256 - k) : 8'(k);
  endfunction

  task automatic send_random_packet;
    logic [7:0] hdr;
    hdr = 8'($urandom_range(255));
    if ($urandom_range(99) < 85) begin
      hdr[HdrOne] = 1'b1;
      hdr[HdrXOvf] = 1'b0;
      hdr[HdrYOvf] = 1'b0;
    end
    send_byte(hdr);
    send_byte(pick_delta(hdr[HdrXSign]));
    send_byte(pick_delta(hdr[HdrYSign]));
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirRows[i]) begin
      send_byte(DirRows[i].hdr);
      send_byte(DirRows[i].dx);
      pinned_rpt = DirRows[i].rpt;
      pin_valid = DirRows[i].pinned;
      send_byte(DirRows[i].dy);
    end
    drain();

    for (int s = 0; s < NumSetups; s++) begin
      if (s > 0) begin
        write_reg(RegClampWidth, Setups[s].clamp_width);
        write_reg(RegClampHeight, Setups[s].clamp_height);
        write_reg(RegIconSize, {2'b00, Setups[s].icon_size});
        write_reg(RegDisplayWidth, Setups[s].display_width);
      end
      for (int p = 0; p < PacketsPerSetup; p++) begin
        if (p % 25 == 0) begin
          send_idle_pct = ModeSend[(p / 25 + s) % 4];
          stall_pct = ModeStall[(p / 25 + s) % 4];
        end
        send_random_packet();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ps2mct_pkg.sv
hw/rtl/ps2mct_update.sv
hw/rtl/ps2_mouse_cursor_tracker.sv
bench/ps2_mouse_cursor_tracker_test.sv
